// ----- hdl/frp_pkg.sv -----
// Shared types, constants and helper functions for the framed ring producer.
package frp_pkg;

	// Ring geometry
	localparam int RING_BYTES   = 4096;
	localparam int HEADER_BYTES = 3;
	localparam int PTR_W        = $clog2(RING_BYTES);
	localparam int CNT_W        = PTR_W + 1;
	localparam int LEN_W        = 16;
	localparam int CMP_W        = LEN_W + 2;
	localparam int MAX_LEN      = RING_BYTES - 1 - HEADER_BYTES;
	localparam int BYTE_W       = 8;

	// Field widths
	localparam int CMD_W  = 2;
	localparam int STAT_W = 3;
	localparam int FREE_W = 12;

	// Item commands
	localparam logic [CMD_W-1:0] CMD_BEGIN   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PAYLOAD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NO_ROOM  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NO_FRAME = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [BYTE_W-1:0] frame_cmd;
		logic [LEN_W-1:0]  frame_len;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] read_byte;
		logic              frame_done;
		logic [FREE_W-1:0] free_space;
	} result_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take;
		logic eval;
		logic hdr1;
		logic hdr2;
		logic rd_capture;
		logic out_load;
	} ctl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_begin;
		logic is_read;
		logic fits;
		logic empty;
		logic out_free;
	} sts_t;

	// Advance a ring pointer with wraparound
	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + 1'b1;
	endfunction

	// Free bytes between the published write pointer and the read pointer
	function automatic logic [CNT_W-1:0] ring_free(input logic [PTR_W-1:0] wp,
			input logic [PTR_W-1:0] rp);
		logic [CNT_W-1:0] used;
		if (wp >= rp) begin
			used = {1'b0, wp} - {1'b0, rp};
		end else begin
			used = {1'b0, wp} + CNT_W'(RING_BYTES) - {1'b0, rp};
		end
		return CNT_W'(RING_BYTES - 1) - used;
	endfunction

endpackage

// ----- hdl/frp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module frp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/frp_datapath.sv -----
// Datapath: ring pointers, frame counters, ring memory and result register.
module frp_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  frp_pkg::item_t   item,
	input  logic             result_ready,
	input  frp_pkg::ctl_t    ctl,
	output frp_pkg::sts_t    sts,
	output frp_pkg::result_t result,
	output logic             result_valid
);

	logic [frp_pkg::PTR_W-1:0]  pub_q, work_q, rd_q;
	logic [frp_pkg::LEN_W-1:0]  store_q, drop_q, len_q;
	logic                       open_q;
	logic                       out_valid_q;
	frp_pkg::item_t             item_q;
	frp_pkg::result_t           out_q;
	logic [frp_pkg::STAT_W-1:0] res_status_q;
	logic [frp_pkg::BYTE_W-1:0] res_byte_q;
	logic                       res_done_q;

	logic [frp_pkg::CNT_W-1:0]  free_cur;
	logic                       len_over;
	logic [frp_pkg::LEN_W-1:0]  len_cut;
	logic [frp_pkg::LEN_W-1:0]  drop_init;
	logic [frp_pkg::CMP_W-1:0]  total;
	logic                       fits;
	logic                       empty;
	logic [frp_pkg::PTR_W-1:0]  work_inc;
	logic                       is_begin, is_payload, is_read;
	logic                       store_left;

	logic                       ram_we, ram_re;
	logic [frp_pkg::PTR_W-1:0]  ram_waddr;
	logic [frp_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

	// Space check and length cut for a begin item
	assign free_cur   = frp_pkg::ring_free(pub_q, rd_q);
	assign len_over   = frp_pkg::CMP_W'(item_q.frame_len) > frp_pkg::CMP_W'(frp_pkg::MAX_LEN);
	assign len_cut    = len_over ? frp_pkg::LEN_W'(frp_pkg::MAX_LEN) : item_q.frame_len;
	assign drop_init  = item_q.frame_len - len_cut;
	assign total      = frp_pkg::CMP_W'(frp_pkg::HEADER_BYTES) + frp_pkg::CMP_W'(len_cut);
	assign fits       = frp_pkg::CMP_W'(free_cur) >= total;
	assign empty      = (rd_q == pub_q);
	assign work_inc   = frp_pkg::ring_next(work_q);
	assign store_left = (store_q != '0);

	assign is_begin   = (item_q.command == frp_pkg::CMD_BEGIN);
	assign is_payload = (item_q.command == frp_pkg::CMD_PAYLOAD);
	assign is_read    = (item_q.command == frp_pkg::CMD_READ);

	assign sts.is_begin = is_begin;
	assign sts.is_read  = is_read;
	assign sts.fits     = fits;
	assign sts.empty    = empty;
	assign sts.out_free = !out_valid_q || result_ready;

	// Ring memory port control
	assign ram_we = (ctl.eval && is_begin && fits) || ctl.hdr1 || ctl.hdr2 ||
		(ctl.eval && is_payload && open_q && store_left);
	assign ram_waddr = (ctl.eval && is_begin) ? pub_q : work_q;
	assign ram_re    = ctl.eval && is_read && !empty;

	always_comb begin
		if (ctl.eval && is_begin) begin
			ram_wdata = item_q.frame_cmd;
		end else if (ctl.hdr1) begin
			ram_wdata = len_q[7:0];
		end else if (ctl.hdr2) begin
			ram_wdata = len_q[15:8];
		end else begin
			ram_wdata = item_q.data_byte;
		end
	end

	frp_ram #(
		.WIDTH(frp_pkg::BYTE_W),
		.DEPTH(frp_pkg::RING_BYTES)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

	// Pointers, frame counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_q       <= '0;
			work_q      <= '0;
			rd_q        <= '0;
			store_q     <= '0;
			drop_q      <= '0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.eval) begin
				case (item_q.command)
					frp_pkg::CMD_BEGIN: begin
						// abandon any open frame, then reserve the new one
						open_q  <= fits && (len_cut != '0 || drop_init != '0);
						store_q <= fits ? len_cut : '0;
						drop_q  <= fits ? drop_init : '0;
						work_q  <= fits ? frp_pkg::ring_next(pub_q) : pub_q;
					end
					frp_pkg::CMD_PAYLOAD: begin
						if (open_q) begin
							if (store_left) begin
								work_q  <= work_inc;
								store_q <= store_q - 1'b1;
								if (store_q == frp_pkg::LEN_W'(1)) begin
									pub_q <= work_inc;
									if (drop_q == '0) begin
										open_q <= 1'b0;
									end
								end
							end else begin
								if (drop_q != '0) begin
									drop_q <= drop_q - 1'b1;
								end
								if (drop_q <= frp_pkg::LEN_W'(1)) begin
									open_q <= 1'b0;
								end
							end
						end
					end
					frp_pkg::CMD_READ: begin
						if (!empty) begin
							rd_q <= frp_pkg::ring_next(rd_q);
						end
					end
					default: begin
					end
				endcase
			end else if (ctl.hdr1) begin
				work_q <= work_inc;
			end else if (ctl.hdr2) begin
				work_q <= work_inc;
				// a zero-length frame is published with its header
				if (len_q == '0) begin
					pub_q <= work_inc;
				end
			end

			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, result fields and output register
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			item_q       <= item;
			res_status_q <= frp_pkg::STAT_OK;
			res_byte_q   <= '0;
			res_done_q   <= 1'b0;
		end else if (ctl.eval) begin
			case (item_q.command)
				frp_pkg::CMD_BEGIN: begin
					len_q <= len_cut;
					if (!fits) begin
						res_status_q <= frp_pkg::STAT_NO_ROOM;
					end
				end
				frp_pkg::CMD_PAYLOAD: begin
					if (!open_q) begin
						res_status_q <= frp_pkg::STAT_NO_FRAME;
					end else if (store_left) begin
						if (store_q == frp_pkg::LEN_W'(1)) begin
							res_done_q <= 1'b1;
						end
					end else begin
						res_status_q <= frp_pkg::STAT_DROPPED;
					end
				end
				frp_pkg::CMD_READ: begin
					if (empty) begin
						res_status_q <= frp_pkg::STAT_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end else if (ctl.hdr2) begin
			if (len_q == '0) begin
				res_done_q <= 1'b1;
			end
		end else if (ctl.rd_capture) begin
			res_byte_q <= ram_rdata;
		end

		if (ctl.out_load) begin
			out_q.status     <= res_status_q;
			out_q.read_byte  <= res_byte_q;
			out_q.frame_done <= res_done_q;
			out_q.free_space <= frp_pkg::FREE_W'(free_cur);
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule

// ----- hdl/frp_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
module frp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  frp_pkg::sts_t sts,
	output frp_pkg::ctl_t ctl
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_HDR1   = 3'd2;
	localparam logic [2:0] S_HDR2   = 3'd3;
	localparam logic [2:0] S_RDWAIT = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0] state_q, state_d;

	assign item_ready = (state_q == S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					ctl.take = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				ctl.eval = 1'b1;
				if (sts.is_begin && sts.fits) begin
					state_d = S_HDR1;
				end else if (sts.is_read && !sts.empty) begin
					state_d = S_RDWAIT;
				end else begin
					state_d = S_OUT;
				end
			end
			S_HDR1: begin
				ctl.hdr1 = 1'b1;
				state_d  = S_HDR2;
			end
			S_HDR2: begin
				ctl.hdr2 = 1'b1;
				state_d  = S_OUT;
			end
			S_RDWAIT: begin
				ctl.rd_capture = 1'b1;
				state_d        = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/framed_ring_producer_core.sv -----
// Top level of the framed ring producer: controller plus datapath.
//
// A byte ring of frp_pkg::RING_BYTES entries holding frames of a command byte,
// a 16-bit little-endian length and the payload; one slot always stays unused.
// Each accepted item gives exactly one result. Items are handled one at a
// time: each is taken in S_IDLE and evaluated in S_EVAL. A consumer read then
// passes S_RDWAIT for the registered read of the ring memory, an accepted
// begin passes S_HDR1 and S_HDR2, since the three header bytes go through
// the single write port of the ring memory one per cycle, and a payload
// byte, a drop, a refused begin or a read of an empty ring go to S_OUT.
// The result is loaded into the output register in S_OUT, and the next
// transfer can be taken in the cycle after that. A result still held in the
// output register while result_ready is low stalls the next item in S_OUT
// until the register is free. The ring memory needs no clearing after
// reset: only published bytes, always written first, are ever read.
module framed_ring_producer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  frp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output frp_pkg::result_t result
);

	frp_pkg::ctl_t ctl;
	frp_pkg::sts_t sts;

	frp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.ctl        (ctl)
	);

	frp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_ready (result_ready),
		.ctl          (ctl),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the framed ring producer core.
`timescale 1ns / 1ps

module tb_top;

	// The command code the package leaves unnamed: answers with free space only
	localparam logic [frp_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOWN_ERRORS = 10;

	// Tracks the ring contents and pointers and holds the replies still owed
	class ring_scoreboard;
		logic [frp_pkg::BYTE_W-1:0] ring_mem [frp_pkg::RING_BYTES];
		int unsigned pub_wp;
		int unsigned work_wp;
		int unsigned rd_p;
		int unsigned store_left;
		int unsigned drop_left;
		bit frame_open;
		frp_pkg::result_t replies_due[$];
		int unsigned errors;

		function int unsigned free_bytes();
			int unsigned used;
			used = (pub_wp + frp_pkg::RING_BYTES - rd_p) % frp_pkg::RING_BYTES;
			return frp_pkg::RING_BYTES - 1 - used;
		endfunction

		function void put_byte(logic [frp_pkg::BYTE_W-1:0] b);
			ring_mem[work_wp] = b;
			work_wp = (work_wp == frp_pkg::RING_BYTES - 1) ? 0 : work_wp + 1;
		endfunction

		// Apply one item to the ring state and return the reply it earns
		function frp_pkg::result_t ring_reply(frp_pkg::item_t it);
			frp_pkg::result_t r;
			int unsigned len;
			r = '0;
			r.status = frp_pkg::STAT_OK;
			case (it.command)
				frp_pkg::CMD_BEGIN: begin
					// any open frame is abandoned
					work_wp = pub_wp;
					frame_open = 0;
					store_left = 0;
					drop_left = 0;
					len = it.frame_len;
					if (frp_pkg::HEADER_BYTES + len > frp_pkg::RING_BYTES - 1)
						len = frp_pkg::MAX_LEN;
					if (free_bytes() < frp_pkg::HEADER_BYTES + len) begin
						r.status = frp_pkg::STAT_NO_ROOM;
					end else begin
						put_byte(it.frame_cmd);
						put_byte(8'(len));
						put_byte(8'(len >> 8));
						store_left = len;
						drop_left = it.frame_len - len;
						if (len == 0) begin
							pub_wp = work_wp;
							r.frame_done = 1'b1;
						end
						frame_open = (len != 0 || drop_left != 0);
					end
				end
				frp_pkg::CMD_PAYLOAD: begin
					if (!frame_open) begin
						r.status = frp_pkg::STAT_NO_FRAME;
					end else if (store_left != 0) begin
						put_byte(it.data_byte);
						store_left--;
						if (store_left == 0) begin
							pub_wp = work_wp;
							r.frame_done = 1'b1;
							if (drop_left == 0)
								frame_open = 0;
						end
					end else begin
						r.status = frp_pkg::STAT_DROPPED;
						if (drop_left != 0)
							drop_left--;
						if (drop_left == 0)
							frame_open = 0;
					end
				end
				frp_pkg::CMD_READ: begin
					if (rd_p == pub_wp) begin
						r.status = frp_pkg::STAT_EMPTY;
					end else begin
						r.read_byte = ring_mem[rd_p];
						rd_p = (rd_p == frp_pkg::RING_BYTES - 1) ? 0 : rd_p + 1;
					end
				end
				default: ;
			endcase
			r.free_space = frp_pkg::FREE_W'(free_bytes());
			return r;
		endfunction

		function void take_item(frp_pkg::item_t it);
			replies_due.push_back(ring_reply(it));
		endfunction

		function void check_reply(frp_pkg::result_t got);
			frp_pkg::result_t want;
			if (replies_due.size() == 0) begin
				errors++;
				if (errors <= SHOWN_ERRORS)
					$display("unexpected reply: status=%0d read=%02h done=%0d free=%0d",
						got.status, got.read_byte, got.frame_done, got.free_space);
				return;
			end
			want = replies_due.pop_front();
			if (got.status !== want.status || got.read_byte !== want.read_byte ||
					got.frame_done !== want.frame_done ||
					got.free_space !== want.free_space) begin
				errors++;
				if (errors <= SHOWN_ERRORS) begin
					$write("reply mismatch: exp status=%0d read=%02h done=%0d free=%0d",
						want.status, want.read_byte, want.frame_done, want.free_space);
					$display(", got status=%0d read=%02h done=%0d free=%0d",
						got.status, got.read_byte, got.frame_done, got.free_space);
				end
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_ready;
	frp_pkg::item_t   item = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	frp_pkg::result_t result;

	int send_idle_pct = 16;
	int recv_idle_pct = 86;
	int cycle_count = 0;

	ring_scoreboard sb = new();

	framed_ring_producer_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function frp_pkg::item_t make_item(logic [frp_pkg::CMD_W-1:0] c,
			logic [frp_pkg::BYTE_W-1:0] fc, logic [frp_pkg::LEN_W-1:0] fl,
			logic [frp_pkg::BYTE_W-1:0] db);
		frp_pkg::item_t it;
		it.command = c;
		it.frame_cmd = fc;
		it.frame_len = fl;
		it.data_byte = db;
		return it;
	endfunction

	// One input transfer, with an optional random gap in front of it
	task send_item(input frp_pkg::item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		sb.take_item(it);
	endtask

	task send_read();
		send_item(make_item(frp_pkg::CMD_READ, 8'($urandom), 16'($urandom), 8'($urandom)));
	endtask

	task send_payload(input logic [frp_pkg::BYTE_W-1:0] b);
		send_item(make_item(frp_pkg::CMD_PAYLOAD, 8'($urandom), 16'($urandom), b));
	endtask

	task send_begin(input logic [frp_pkg::BYTE_W-1:0] fc,
			input logic [frp_pkg::LEN_W-1:0] fl);
		send_item(make_item(frp_pkg::CMD_BEGIN, fc, fl, 8'($urandom)));
	endtask

	// Mostly whole frames with reads mixed in; some cut short, overrun or noise
	task run_traffic(input int n_items);
		int sent;
		int pick;
		int len;
		int nbytes;
		int sel;
		int burst;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
				send_begin(8'($urandom), 16'(len));
				sent++;
				sel = $urandom_range(9);
				nbytes = len;
				if (sel == 0)
					nbytes = $urandom_range(0, len);
				else if (sel == 1)
					nbytes = len + 1;
				for (int i = 0; i < nbytes && sent < n_items; i++) begin
					if ($urandom_range(99) < 30) begin
						send_read();
						sent++;
					end
					send_payload(8'($urandom));
					sent++;
				end
			end else if (pick < 85) begin
				burst = $urandom_range(1, 20);
				repeat (burst) send_read();
				sent += burst;
			end else begin
				send_item(make_item(frp_pkg::CMD_W'($urandom_range(3)), 8'($urandom),
					16'($urandom), 8'($urandom)));
				sent++;
			end
		end
	endtask

	// Reply side: check each accepted reply, then pick next cycle's ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_reply(result);
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty ring, stray payload, no-op, zero-length frame
		send_item(make_item(frp_pkg::CMD_READ, 8'h00, 16'h0000, 8'h00));
		send_item(make_item(frp_pkg::CMD_PAYLOAD, 8'h00, 16'h0000, 8'hff));
		send_item(make_item(CMD_NOP, 8'hff, 16'hffff, 8'hff));
		send_begin(8'hff, 16'h0000);
		// oversized frame is cut but still does not fit behind the header
		send_begin(8'h00, 16'hffff);
		repeat (3) send_read();
		// oversized frame fits an empty ring, then is abandoned by a new begin
		send_begin(8'ha5, 16'hffff);
		send_payload(8'h11);
		send_payload(8'h22);
		send_begin(8'h5a, 16'h0002);
		send_payload(8'h00);
		send_payload(8'hff);
		send_payload(8'h33);
		// exact fit of the largest frame once the ring is empty
		send_begin(8'h3c, 16'(frp_pkg::MAX_LEN));
		repeat (5) send_read();
		send_begin(8'h3c, 16'(frp_pkg::MAX_LEN));
		send_begin(8'hc3, 16'h0001);
		send_payload(8'h80);
		repeat (4) send_read();

		// Random traffic under three idling mixes
		run_traffic(225);
		send_idle_pct = 86;
		recv_idle_pct = 16;
		run_traffic(225);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_traffic(225);
		item_valid <= 1'b0;

		while (sb.replies_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.replies_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
